[sv/hsb_to_argb_convert_defines.svh]
// Assertion macros for the HSB to ARGB converter RTL, used by its output buffer.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef HSB_TO_ARGB_CONVERT_DEFINES_SVH
`define HSB_TO_ARGB_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside of reset.
`define HSBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define HSBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HSBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define HSBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/hsba_pkg.sv]
// Package for the HSB to ARGB converter: widths, constants and pipeline depth.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package hsba_pkg;

    // Field widths.
    localparam int ALPHA_W  = 8;
    localparam int HUE_W    = 9;
    localparam int PCT_W    = 7;
    localparam int CHAN_W   = 8;
    localparam int WORD_W   = 32;

    // Percent and hue limits.
    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
    localparam logic [HUE_W-1:0] HUE_SECTOR = 9'd60;
    localparam logic [HUE_W-1:0] HUE_PLATEAU_END = 9'd180;
    localparam logic [HUE_W-1:0] HUE_FALL_END    = 9'd240;
    localparam logic [5:0]       F_MAX      = 6'd60;

    // Hue offsets that select the channel: 60 times 5, 3 and 1.
    localparam logic [HUE_W-1:0] RED_OFS    = 9'd300;
    localparam logic [HUE_W-1:0] GREEN_OFS  = 9'd180;
    localparam logic [HUE_W-1:0] BLUE_OFS   = 9'd60;

    // Channel arithmetic: d = 6000 - S*f, m = B*d, y = (255*m + 300000) >> 6.
    localparam logic [12:0] D_FULL     = 13'd6000;
    localparam logic [27:0] ROUND_BIAS = 28'd300000;

    // y / 9375 as (y * ceil(2^36 / 9375)) >> 36, exact for y below 2^22.
    localparam logic [22:0] RECIP_K     = 23'd7330078;
    localparam int          RECIP_SHIFT = 36;

    // Register stages between the input beat and the output buffer.
    localparam int PIPE_DEPTH = 6;

    typedef logic [ALPHA_W-1:0] t_alpha;
    typedef logic [HUE_W-1:0]   t_hue;
    typedef logic [PCT_W-1:0]   t_pct;
    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [WORD_W-1:0]  t_word;

endpackage

[sv/hsba_ifs.sv]
// Valid/ready stream interfaces for the HSB to ARGB converter.
// Depends on hsba_pkg for the payload types.
`timescale 1ns / 1ps

interface hsba_in_if;
    import hsba_pkg::*;

    logic   valid;
    logic   ready;
    t_alpha alpha_in;
    t_hue   hue_deg;
    t_pct   sat_pct;
    t_pct   bright_pct;

    modport source (output valid, alpha_in, hue_deg, sat_pct, bright_pct, input ready);
    modport sink   (input valid, alpha_in, hue_deg, sat_pct, bright_pct, output ready);
endinterface

interface hsba_out_if;
    import hsba_pkg::*;

    logic  valid;
    logic  ready;
    t_word argb_word;

    modport source (output valid, argb_word, input ready);
    modport sink   (input valid, argb_word, output ready);
endinterface

[sv/hsb_to_argb_convert.sv]
// HSB to ARGB converter: accepts one color per clock and returns one packed
// ARGB word per color. The stage that reduces the hue and limits the
// percentages loads on the input beat itself, five stages per channel follow
// to form the ramp, the saturation term, the brightness product, the rounded
// numerator and the reciprocal multiply that divides by 600000, and a
// two-entry output buffer presents the word. Throughput is one beat per
// cycle; input ready depends only on that buffer, so it drops only while the
// buffer's spare entry holds a beat, which happens when the output stalls as
// another beat arrives, and it returns the cycle after the output takes a word.
`timescale 1ns / 1ps

module hsb_to_argb_convert
    import hsba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hsba_in_if.sink    i_in,
    hsba_out_if.source o_out
);

    logic   en;
    t_hue   n_hue;
    t_pct   n_sat;
    t_pct   n_bri;
    t_hue   r_hue;
    t_pct   r_sat;
    t_pct   r_bri;
    t_alpha r_alpha [PIPE_DEPTH];
    logic [PIPE_DEPTH-1:0] r_vld;
    t_chan  red;
    t_chan  green;
    t_chan  blue;
    t_word  word;

    // The whole pipeline moves whenever the output buffer has room.
    assign i_in.ready = en;

    // Stage one: wrap the hue once and limit both percentages to 100.
    always_comb begin
        n_hue = (i_in.hue_deg >= HUE_FULL) ? (i_in.hue_deg - HUE_FULL) : i_in.hue_deg;
        n_sat = (i_in.sat_pct > PCT_FULL) ? PCT_FULL : i_in.sat_pct;
        n_bri = (i_in.bright_pct > PCT_FULL) ? PCT_FULL : i_in.bright_pct;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_bri <= n_bri;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in.valid};
        end
    end

    // Alpha rides a delay line matching the channel datapath.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_alpha[0] <= i_in.alpha_in;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    // One datapath per color channel.
    hsba_chan u_red (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_hue_ofs(RED_OFS),
        .i_hue    (r_hue),
        .i_sat    (r_sat),
        .i_bright (r_bri),
        .o_val    (red)
    );

    hsba_chan u_green (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_hue_ofs(GREEN_OFS),
        .i_hue    (r_hue),
        .i_sat    (r_sat),
        .i_bright (r_bri),
        .o_val    (green)
    );

    hsba_chan u_blue (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_hue_ofs(BLUE_OFS),
        .i_hue    (r_hue),
        .i_sat    (r_sat),
        .i_bright (r_bri),
        .o_val    (blue)
    );

    assign word = {r_alpha[PIPE_DEPTH-1], red, green, blue};

    // Output buffer.
    hsba_skid u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_vld[PIPE_DEPTH-1]),
        .i_data (word),
        .o_ready(en),
        .o_out  (o_out)
    );

endmodule

[sv/hsba_chan.sv]
// One color channel datapath: hue sector, saturation term, brightness scale and rounding divide.
// Depends on hsba_pkg; five register stages that advance together on i_en.
`timescale 1ns / 1ps

module hsba_chan
    import hsba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_hue  i_hue_ofs,
    input  t_hue  i_hue,
    input  t_pct  i_sat,
    input  t_pct  i_bright,
    output t_chan o_val
);

    logic [HUE_W:0] hue_sum;
    t_hue           h;
    t_hue           fall;
    logic [5:0]     n_f;
    logic [12:0]    sf;
    logic [12:0]    n_d;
    logic [19:0]    n_m;
    logic [27:0]    num;
    logic [21:0]    n_y;
    logic [44:0]    n_prod;
    logic [8:0]     quot;

    logic [5:0]  r_f;
    t_pct        r_sat2;
    t_pct        r_bri2;
    logic [12:0] r_d;
    t_pct        r_bri3;
    logic [19:0] r_m;
    logic [21:0] r_y;
    logic [44:0] r_prod;

    // Rotate the hue by the channel offset and find the ramp value f in 0..60.
    always_comb begin
        hue_sum = {1'b0, i_hue} + {1'b0, i_hue_ofs};
        if (hue_sum >= {1'b0, HUE_FULL}) begin
            h = hue_sum[HUE_W-1:0] - HUE_FULL;
        end else begin
            h = hue_sum[HUE_W-1:0];
        end
        fall = HUE_FALL_END - h;
        if (h < HUE_SECTOR) begin
            n_f = h[5:0];
        end else if (h <= HUE_PLATEAU_END) begin
            n_f = F_MAX;
        end else if (h < HUE_FALL_END) begin
            n_f = fall[5:0];
        end else begin
            n_f = '0;
        end
    end

    // Saturation term, brightness product and rounded numerator.
    always_comb begin
        sf     = {6'b0, r_sat2} * {7'b0, r_f};
        n_d    = D_FULL - sf;
        n_m    = {13'b0, r_bri3} * {7'b0, r_d};
        num    = ({8'b0, r_m} << 8) - {8'b0, r_m} + ROUND_BIAS;
        n_y    = num[27:6];
        n_prod = {23'b0, r_y} * {22'b0, RECIP_K};
    end

    // Pipeline registers; payload only, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f    <= n_f;
            r_sat2 <= i_sat;
            r_bri2 <= i_bright;
            r_d    <= n_d;
            r_bri3 <= r_bri2;
            r_m    <= n_m;
            r_y    <= n_y;
            r_prod <= n_prod;
        end
    end

    // Quotient of the reciprocal multiply, clamped to a byte.
    always_comb begin
        quot  = r_prod[RECIP_SHIFT+8:RECIP_SHIFT];
        o_val = quot[8] ? {CHAN_W{1'b1}} : quot[CHAN_W-1:0];
    end

endmodule

[sv/hsba_skid.sv]
// Two-entry output buffer that parts the pipeline from the result channel.
// Depends on hsba_pkg, hsba_out_if and the assertion macros header.
`timescale 1ns / 1ps
`include "hsb_to_argb_convert_defines.svh"

module hsba_skid
    import hsba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_word i_data,
    output logic  o_ready,
    hsba_out_if.source o_out
);

    logic  r_main_vld;
    logic  r_skid_vld;
    t_word r_main;
    t_word r_skid;
    logic  n_main_vld;
    logic  n_skid_vld;
    logic  in_beat;
    logic  out_beat;
    logic  load_main;

    assign o_ready       = !r_skid_vld;
    assign o_out.valid     = r_main_vld;
    assign o_out.argb_word = r_main;

    // Main register refills when empty or drained; the spare catches a beat otherwise.
    always_comb begin
        in_beat    = i_valid && !r_skid_vld;
        out_beat   = r_main_vld && o_out.ready;
        load_main  = !r_main_vld || out_beat;
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        if (load_main) begin
            n_main_vld = r_skid_vld || in_beat;
            n_skid_vld = 1'b0;
        end else if (in_beat) begin
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // Data registers; no reset needed.
    always_ff @(posedge i_clk) begin
        if (load_main) begin
            r_main <= r_skid_vld ? r_skid : i_data;
        end else if (in_beat) begin
            r_skid <= i_data;
        end
    end

    // The spare entry is only ever used behind a full main register.
    `HSBA_ASSERT_NOW(a_skid_behind_main, i_clk, i_rst_n, r_skid_vld, r_main_vld,
        "spare entry holds a beat while the main register is empty")
    // A beat arriving against a stalled, full output must land in the spare.
    `HSBA_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n,
        in_beat && r_main_vld && !o_out.ready, r_skid_vld,
        "beat lost while the output was stalled")
    // Draining with a spare beat pending must keep the output valid.
    `HSBA_ASSERT_NXT(a_skid_moves_up, i_clk, i_rst_n, r_skid_vld && o_out.ready,
        r_main_vld, "spare beat not moved to the output")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the HSB to ARGB converter.
// Depends on hsba_pkg, the stream interfaces and the hsb_to_argb_convert RTL.
`timescale 1ns / 1ps

module testbench;
    import hsba_pkg::*;

    localparam int RANDOM_COLORS = 1400;
    localparam int DIRECTED_ROWS = 20;
    localparam int GAP_PCT       = 16;

    // One directed color, with a hand-derived word where the answer is obvious.
    typedef struct packed {
        t_alpha alpha;
        t_hue   hue;
        t_pct   sat;
        t_pct   bright;
        bit     typed;
        t_word  word;
    } t_color_row;

    logic i_clk;
    logic i_rst_n;

    hsba_in_if  color_bus ();
    hsba_out_if argb_bus ();

    hsb_to_argb_convert uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (color_bus),
        .o_out   (argb_bus)
    );

    t_word pending_argb[$];
    int    error_count;
    bit    no_gaps;

    t_color_row directed_rows [DIRECTED_ROWS] = '{
        // Primary and secondary colors at full saturation and brightness.
        '{8'hFF, 9'd0,   7'd100, 7'd100, 1'b1, 32'hFFFF0000},
        '{8'h00, 9'd120, 7'd100, 7'd100, 1'b1, 32'h0000FF00},
        '{8'h80, 9'd240, 7'd100, 7'd100, 1'b1, 32'h800000FF},
        '{8'h12, 9'd60,  7'd100, 7'd100, 1'b1, 32'h12FFFF00},
        '{8'h34, 9'd180, 7'd100, 7'd100, 1'b1, 32'h3400FFFF},
        '{8'h56, 9'd300, 7'd100, 7'd100, 1'b1, 32'h56FF00FF},
        // No saturation gives white; no brightness gives black.
        '{8'hA5, 9'd0,   7'd0,   7'd100, 1'b1, 32'hA5FFFFFF},
        '{8'h5A, 9'd200, 7'd100, 7'd0,   1'b1, 32'h5A000000},
        '{8'h00, 9'd0,   7'd0,   7'd0,   1'b1, 32'h00000000},
        // Hue wrap past 360 and percentages above 100.
        '{8'h00, 9'd360, 7'd100, 7'd100, 1'b1, 32'h00FF0000},
        '{8'h7F, 9'd480, 7'd127, 7'd127, 1'b1, 32'h7F00FF00},
        '{8'hFF, 9'd359, 7'd127, 7'd0,   1'b1, 32'hFF000000},
        '{8'hFF, 9'd511, 7'd0,   7'd127, 1'b1, 32'hFFFFFFFF},
        '{8'hFF, 9'd511, 7'd127, 7'd127, 1'b0, 32'h0},
        // Ramps, half-way rounding and small values.
        '{8'h01, 9'd359, 7'd100, 7'd100, 1'b0, 32'h0},
        '{8'hC3, 9'd30,  7'd50,  7'd50,  1'b0, 32'h0},
        '{8'h3C, 9'd90,  7'd101, 7'd100, 1'b0, 32'h0},
        '{8'h00, 9'd0,   7'd0,   7'd50,  1'b0, 32'h0},
        '{8'hAA, 9'd255, 7'd100, 7'd127, 1'b0, 32'h0},
        '{8'h55, 9'd1,   7'd1,   7'd1,   1'b0, 32'h0}
    };

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // One channel of the HSV formula in exact integers.
    function automatic t_chan channel_level(input int unsigned offset,
                                            input int unsigned hue_r,
                                            input int unsigned sat_c,
                                            input int unsigned bright_c);
        int unsigned h;
        int          ramp;
        int unsigned level;
        h = (offset + hue_r) % HUE_FULL;
        ramp = int'(HUE_FALL_END) - int'(h);
        if (int'(h) < ramp)
            ramp = int'(h);
        if (ramp > int'(HUE_SECTOR))
            ramp = int'(HUE_SECTOR);
        if (ramp < 0)
            ramp = 0;
        level = (255 * bright_c * (D_FULL - sat_c * unsigned'(ramp)) + ROUND_BIAS) / 600000;
        if (level > 255)
            level = 255;
        return t_chan'(level);
    endfunction

    // Packed ARGB word for one color.
    function automatic t_word predict_argb(input t_alpha alpha, input t_hue hue,
                                           input t_pct sat, input t_pct bright);
        int unsigned hue_r;
        int unsigned sat_c;
        int unsigned bright_c;
        hue_r    = 32'(hue % HUE_FULL);
        sat_c    = 32'((sat > PCT_FULL) ? PCT_FULL : sat);
        bright_c = 32'((bright > PCT_FULL) ? PCT_FULL : bright);
        return {alpha,
                channel_level(32'(RED_OFS), hue_r, sat_c, bright_c),
                channel_level(32'(GREEN_OFS), hue_r, sat_c, bright_c),
                channel_level(32'(BLUE_OFS), hue_r, sat_c, bright_c)};
    endfunction

    // Offer one color beat, with random gaps, and queue its word on acceptance.
    task automatic send_color(input t_alpha alpha, input t_hue hue, input t_pct sat,
                              input t_pct bright, input bit typed, input t_word word);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
            color_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        color_bus.valid      <= 1'b1;
        color_bus.alpha_in   <= alpha;
        color_bus.hue_deg    <= hue;
        color_bus.sat_pct    <= sat;
        color_bus.bright_pct <= bright;
        do
            @(posedge i_clk);
        while (!color_bus.ready);
        pending_argb.push_back(typed ? word : predict_argb(alpha, hue, sat, bright));
        @(negedge i_clk);
    endtask

    // Output side: random back-pressure, except in the gap-free stretch.
    initial begin
        argb_bus.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        argb_bus.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end

    // Compare each accepted word with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && argb_bus.valid && argb_bus.ready) begin
            if (pending_argb.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected ARGB word %08h", argb_bus.argb_word);
            end else begin
                if (argb_bus.argb_word !== pending_argb[0]) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ARGB mismatch: expected %08h, got %08h",
                                 pending_argb[0], argb_bus.argb_word);
                end
                void'(pending_argb.pop_front());
            end
        end
    end

    // Stimulus: reset, directed table, random colors, then drain.
    initial begin
        t_alpha alpha;
        t_hue   hue;
        t_pct   sat;
        t_pct   bright;
        int     mode;
        error_count          = 0;
        no_gaps              = 1'b0;
        i_rst_n              = 1'b0;
        color_bus.valid      = 1'b0;
        color_bus.alpha_in   = '0;
        color_bus.hue_deg    = '0;
        color_bus.sat_pct    = '0;
        color_bus.bright_pct = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_color(directed_rows[i].alpha, directed_rows[i].hue, directed_rows[i].sat,
                       directed_rows[i].bright, directed_rows[i].typed,
                       directed_rows[i].word);
        end

        // Mostly in-range colors; some wrap the hue or overrange the percentages.
        for (int n = 0; n < RANDOM_COLORS; n++) begin
            no_gaps = (n >= 500) && (n < 800);
            mode    = $urandom_range(0, 9);
            alpha   = t_alpha'($urandom);
            if (mode < 7) begin
                hue    = t_hue'($urandom_range(0, 359));
                sat    = t_pct'($urandom_range(0, 100));
                bright = t_pct'($urandom_range(0, 100));
            end else begin
                hue    = t_hue'($urandom_range(0, 511));
                sat    = t_pct'($urandom_range(0, 127));
                bright = t_pct'($urandom_range(0, 127));
            end
            send_color(alpha, hue, sat, bright, 1'b0, '0);
        end
        no_gaps = 1'b0;
        color_bus.valid <= 1'b0;

        while (pending_argb.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
